/* rtl/core/bdg_pkg.sv */
package bdg_pkg;

  localparam int PIX_W       = 12;
  localparam int DIM_W       = 13;
  localparam int GAIN_W      = 20;
  localparam int BLACK_W     = 9;
  localparam int CHAN_W      = GAIN_W + BLACK_W;
  localparam int NUM_CHAN    = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int BACK_STAGES = 2;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam logic [PIX_W-1:0] PIX_MAX = 12'd4095;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_OFFSET   = 3'd3;
  localparam logic [2:0] REG_CHAN0    = 3'd4;
  localparam logic [2:0] REG_CHAN1    = 3'd5;
  localparam logic [2:0] REG_CHAN2    = 3'd6;
  localparam logic [2:0] REG_CHAN3    = 3'd7;

  typedef struct packed {
    logic [2:0]                          mode;
    logic [DIM_W-1:0]                    frame_width;
    logic [DIM_W-1:0]                    frame_height;
    logic [PIX_W-1:0]                    output_offset;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     chan;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [1:0]       ch;
    logic             en;
  } cmd_t;

endpackage

/* rtl/core/bayer_digital_gain.sv */
// Per-channel black level subtraction and digital gain on a raw Bayer stream.
// Pixels enter in raster order through a queue-style push/full port and leave
// through empty/pop; one pixel per clock is sustained while pop does not stall the
// output, set by the single registered multiplier stage in the back end; an
// accepted pixel passes through the queue, the stage-1 register and the output
// register. The front tracks the raster position and tags each pixel with its
// Bayer channel, a four-entry queue decouples it from the two-stage arithmetic
// back end, which ends in the output register. Registers sit on an APB port at
// byte address 4*index and must only be written while no pixel is in flight.
module bayer_digital_gain #(
  parameter int GAIN_FRACTION_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [bdg_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                        empty,
  input  logic                        pop,
  output logic [bdg_pkg::PIX_W-1:0]   out_pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdg_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdg_pkg::DATA_W-1:0]  pwdata,
  output logic [bdg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bdg_pkg::*;

  cfg_t cfg;
  cmd_t q_wdata;
  cmd_t q_rdata;
  logic q_wr, q_rd, q_full, q_empty;

  assign full = q_full;

  bdg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .push   (push),
    .pixel  (in_pixel_in),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  bdg_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bdg_back #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .pixel_out (out_pixel_out)
  );

endmodule

/* rtl/core/bdg_cfg.sv */
module bdg_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdg_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdg_pkg::DATA_W-1:0]  pwdata,
  output logic [bdg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bdg_pkg::cfg_t               cfg
);
  import bdg_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_MODE:   cfg_nxt.mode          = pwdata[2:0];
        REG_WIDTH:  cfg_nxt.frame_width   = pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.frame_height  = pwdata[DIM_W-1:0];
        REG_OFFSET: cfg_nxt.output_offset = pwdata[PIX_W-1:0];
        REG_CHAN0:  cfg_nxt.chan[0]       = pwdata[CHAN_W-1:0];
        REG_CHAN1:  cfg_nxt.chan[1]       = pwdata[CHAN_W-1:0];
        REG_CHAN2:  cfg_nxt.chan[2]       = pwdata[CHAN_W-1:0];
        REG_CHAN3:  cfg_nxt.chan[3]       = pwdata[CHAN_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {{(DATA_W-3){1'b0}}, cfg_r.mode};
      REG_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_r.frame_width};
      REG_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_r.frame_height};
      REG_OFFSET: prdata = {{(DATA_W-PIX_W){1'b0}}, cfg_r.output_offset};
      REG_CHAN0:  prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg_r.chan[0]};
      REG_CHAN1:  prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg_r.chan[1]};
      REG_CHAN2:  prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg_r.chan[2]};
      REG_CHAN3:  prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg_r.chan[3]};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= 3'd0;
      cfg_r.frame_width   <= 13'd1920;
      cfg_r.frame_height  <= 13'd1080;
      cfg_r.output_offset <= '0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        cfg_r.chan[i] <= 29'd1024;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/bdg_front.sv */
module bdg_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdg_pkg::cfg_t              cfg,
  input  logic                       push,
  input  logic [bdg_pkg::PIX_W-1:0]  pixel,
  input  logic                       q_full,
  output logic                       q_wr,
  output bdg_pkg::cmd_t              q_data
);
  import bdg_pkg::*;

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;

  assign q_wr          = push & ~q_full;
  assign q_data.pixel  = pixel;
  assign q_data.ch     = {col_r[0], row_r[0]} ^ cfg.mode[2:1];
  assign q_data.en     = cfg.mode[0];

  assign col_inc = col_r + 1'b1;
  assign row_inc = row_r + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_wr) begin
      if (col_inc >= cfg.frame_width) begin
        col_nxt = '0;
        row_nxt = (row_inc >= cfg.frame_height) ? '0 : row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/core/bdg_fifo.sv */
module bdg_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  bdg_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output bdg_pkg::cmd_t rdata,
  output logic          empty
);
  import bdg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr & ~do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd & ~do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/bdg_back.sv */
module bdg_back #(
  parameter int GAIN_FRACTION_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdg_pkg::cfg_t              cfg,
  input  logic                       q_empty,
  input  bdg_pkg::cmd_t              q_data,
  output logic                       q_rd,
  input  logic                       pop,
  output logic                       empty,
  output logic [bdg_pkg::PIX_W-1:0]  pixel_out
);
  import bdg_pkg::*;

  localparam int DIFF_W = PIX_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (GAIN_FRACTION_BITS - 1);

  // stage 1: subtract black level and multiply by gain
  logic                     v1_r, v1_nxt;
  logic                     en1_r;
  logic [PIX_W-1:0]         pix1_r;
  logic signed [PROD_W-1:0] prod1_r;
  // stage 2: round, shift, offset, clip into the output register
  logic                     v2_r, v2_nxt;
  logic [PIX_W-1:0]         res2_r;

  logic                     adv1, adv2;
  logic [CHAN_W-1:0]        chan_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  rounded;
  logic signed [SUM_W-1:0]  scaled;
  logic [PIX_W-1:0]         res;

  assign adv2 = ~v2_r | pop;
  assign adv1 = ~v1_r | adv2;
  assign q_rd = adv1 & ~q_empty;

  assign chan_sel = cfg.chan[q_data.ch];
  assign diff = $signed({1'b0, q_data.pixel})
              - $signed({{(DIFF_W-BLACK_W){1'b0}}, chan_sel[CHAN_W-1:GAIN_W]});
  assign prod = PROD_W'(diff) * $signed({1'b0, chan_sel[GAIN_W-1:0]});

  assign rounded = (SUM_W'(prod1_r) + HALF) >>> GAIN_FRACTION_BITS;
  assign scaled  = rounded + $signed({{(SUM_W-PIX_W){1'b0}}, cfg.output_offset});

  always_comb begin
    if (!en1_r) begin
      res = pix1_r;
    end else if (scaled < 0) begin
      res = '0;
    end else if (scaled > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = scaled[PIX_W-1:0];
    end
  end

  assign v1_nxt = adv1 ? ~q_empty : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      en1_r   <= q_data.en;
      pix1_r  <= q_data.pixel;
      prod1_r <= prod;
    end
    if (adv2 & v1_r) begin
      res2_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  assign empty     = ~v2_r;
  assign pixel_out = res2_r;

endmodule

/* rtl/core/bdg_checker.sv */
module bdg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       push,
  input logic                       full,
  input logic                       pop,
  input logic                       empty,
  input logic [bdg_pkg::PIX_W-1:0]  out_pixel_out,
  input logic                       pready
);
  import bdg_pkg::*;

  localparam int CAP   = QUEUE_DEPTH + BACK_STAGES;
  localparam int CNT_W = $clog2(CAP + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = push & ~full;
  assign out_acc = pop & ~empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc & ~out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_acc & ~in_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> empty)
    else $error("result shown with no item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(CAP)) |-> full)
    else $error("more items in flight than the block can hold");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_out)))
    else $error("stalled result changed");

endmodule

bind bayer_digital_gain bdg_checker u_bdg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .pop           (pop),
  .empty         (empty),
  .out_pixel_out (out_pixel_out),
  .pready        (pready)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bdg_pkg::*;

  localparam int FRAC_BITS     = 10;
  localparam int RANDOM_PIXELS = 378;
  localparam int STALL_LIMIT   = 3000;
  localparam int N_DIRECTED    = 36;

  typedef enum logic {OP_PIXEL, OP_WRITE} stim_op_t;

  typedef struct packed {
    stim_op_t          op;
    logic [2:0]        idx;
    logic [DATA_W-1:0] data;
    logic [PIX_W-1:0]  pix;
    logic              known;
    logic [PIX_W-1:0]  want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // pass-through after reset
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h000, 1'b1, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hFFF, 1'b1, 12'hFFF},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hAAA, 1'b1, 12'hAAA},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h555, 1'b1, 12'h555},
    // unity gain, zero black level
    '{OP_WRITE, REG_MODE,   32'd1,          12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h000, 1'b1, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hFFF, 1'b1, 12'hFFF},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h001, 1'b1, 12'h001},
    // shrink frame below the current column, extreme channel settings
    '{OP_WRITE, REG_WIDTH,  32'd2,          12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_HEIGHT, 32'd2,          12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_CHAN0,  32'h1FFF_FFFF,  12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_CHAN1,  32'h0000_0000,  12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_CHAN2,  32'h0640_0400,  12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_CHAN3,  32'h0000_0800,  12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hFFF, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h064, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h063, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h800, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h7FF, 1'b0, 12'h000},
    '{OP_WRITE, REG_OFFSET, 32'd4095,       12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hFFF, 1'b0, 12'h000},
    '{OP_WRITE, REG_MODE,   32'd7,          12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h123, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hFFF, 1'b0, 12'h000},
    // zero frame size
    '{OP_WRITE, REG_WIDTH,  32'd0,          12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_HEIGHT, 32'd0,          12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h0FF, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h800, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h001, 1'b0, 12'h000},
    '{OP_WRITE, REG_WIDTH,  32'd8191,       12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_HEIGHT, 32'd8191,       12'h000, 1'b0, 12'h000},
    '{OP_WRITE, REG_OFFSET, 32'd0,          12'h000, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'hAAA, 1'b0, 12'h000},
    '{OP_PIXEL, REG_MODE,   32'd0,          12'h555, 1'b0, 12'h000}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [PIX_W-1:0]  in_pixel_in = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t              gain_model;
  logic [DIM_W-1:0]  raster_row;
  logic [DIM_W-1:0]  raster_col;
  logic [PIX_W-1:0]  pixel_expect_q [$];

  int unsigned err_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned directed_pixels = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  bayer_digital_gain #(
    .GAIN_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_pixel_in  (in_pixel_in),
    .empty        (empty),
    .pop          (pop),
    .out_pixel_out(out_pixel_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic logic [PIX_W-1:0] predict_pixel(input logic [PIX_W-1:0] pix);
    logic [1:0]        ch;
    logic [CHAN_W-1:0] creg;
    longint            acc;
    if (!gain_model.mode[0]) return pix;
    ch   = {raster_col[0], raster_row[0]} ^ gain_model.mode[2:1];
    creg = gain_model.chan[ch];
    acc  = (longint'(pix) - longint'(creg[GAIN_W +: BLACK_W])) * longint'(creg[GAIN_W-1:0])
           + (longint'(1) << (FRAC_BITS - 1));
    acc  = (acc >>> FRAC_BITS) + longint'(gain_model.output_offset);
    if (acc < 0) return '0;
    if (acc > longint'(PIX_MAX)) return PIX_MAX;
    return acc[PIX_W-1:0];
  endfunction

  task automatic step_raster();
    raster_col = raster_col + 1'b1;
    if (raster_col >= gain_model.frame_width) begin
      raster_col = '0;
      raster_row = raster_row + 1'b1;
      if (raster_row >= gain_model.frame_height) raster_row = '0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [DATA_W-1:0] rand_reg(input logic [2:0] idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (idx)
      REG_MODE: begin
        if (r < 80) return DATA_W'($urandom_range(0, 3) * 2 + 1);
        return DATA_W'($urandom_range(0, 7));
      end
      REG_WIDTH, REG_HEIGHT: begin
        if (r < 6) return 0;
        if (r < 12) return 1;
        if (r < 18) return 8191;
        return DATA_W'($urandom_range(2, 9));
      end
      REG_OFFSET: begin
        if (r < 10) return 0;
        if (r < 20) return 4095;
        return DATA_W'($urandom_range(0, 400));
      end
      default: begin
        if (r < 8) return 0;
        if (r < 16) return 32'h1FFF_FFFF;
        if (r < 30) return $urandom & 32'h1FFF_FFFF;
        return (DATA_W'($urandom_range(0, 300)) << GAIN_W) | DATA_W'($urandom_range(128, 8192));
      end
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return PIX_MAX;
    return PIX_W'($urandom_range(0, 4095));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic known,
                            input logic [PIX_W-1:0] want);
    int unsigned      gap;
    logic [PIX_W-1:0] predicted;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (full);
    predicted = predict_pixel(pix);
    step_raster();
    pixel_expect_q.push_back(known ? want : predicted);
    pixels_sent++;
  endtask

  task automatic drain_pixels();
    push <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
  endtask

  // leaves psel high so a following write starts with its setup cycle
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE:   gain_model.mode          = val[2:0];
      REG_WIDTH:  gain_model.frame_width   = val[DIM_W-1:0];
      REG_HEIGHT: gain_model.frame_height  = val[DIM_W-1:0];
      REG_OFFSET: gain_model.output_offset = val[PIX_W-1:0];
      default:    gain_model.chan[2'(idx - REG_CHAN0)] = val[CHAN_W-1:0];
    endcase
    reg_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) report_mismatch("register readback", prdata, val);
  endtask

  task automatic release_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned      hold;
    logic [PIX_W-1:0] want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        results_seen++;
        if (pixel_expect_q.size() == 0) begin
          report_mismatch("pixel with nothing pending", DATA_W'(out_pixel_out), '0);
        end else begin
          want = pixel_expect_q.pop_front();
          if (out_pixel_out !== want) begin
            report_mismatch("pixel_out", DATA_W'(out_pixel_out), DATA_W'(want));
          end
        end
        hold = pick_gap();
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic bus_open;
    bus_open = 1'b0;
    gain_model.mode          = '0;
    gain_model.frame_width   = DIM_W'(1920);
    gain_model.frame_height  = DIM_W'(1080);
    gain_model.output_offset = '0;
    for (int i = 0; i < NUM_CHAN; i++) gain_model.chan[i] = CHAN_W'(1024);
    raster_row = '0;
    raster_col = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].op == OP_WRITE) begin
        if (!bus_open) begin
          drain_pixels();
          bus_open = 1'b1;
        end
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
      end else begin
        if (bus_open) begin
          release_bus();
          bus_open = 1'b0;
        end
        send_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
      end
    end
    directed_pixels = pixels_sent;

    while (pixels_sent < directed_pixels + RANDOM_PIXELS) begin
      drain_pixels();
      no_idle = 1'b0;
      for (int i = REG_MODE; i <= REG_CHAN3; i++) write_reg(3'(i), rand_reg(3'(i)));
      release_bus();
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(20, 60)) begin
        if (pixels_sent < directed_pixels + RANDOM_PIXELS) begin
          send_pixel(rand_pixel(), 1'b0, '0);
        end
      end
    end

    drain_pixels();
    no_idle = 1'b0;
    repeat (8) @(posedge clk);

    $display("%0d pixels (%0d directed), %0d results checked, %0d register writes",
             pixels_sent, directed_pixels, results_seen, reg_writes);
    $display("covered bypass, all bayer patterns, zero/min/max frame sizes, clip at 0 and 4095");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
